@@ rtl/sbmq_pkg.sv @@
// Package for the shared-buffer multi-queue: operation and status codes,
// fixed field widths. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sbmq_pkg;

	localparam int QID_W  = 2;
	localparam int DATA_W = 32;

	typedef enum logic {
		OP_ENQ = 1'b0,
		OP_DEQ = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

endpackage

`default_nettype wire

@@ rtl/sbmq_if.sv @@
// Request and response channel interfaces for the shared-buffer multi-queue.
// Depends on sbmq_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface sbmq_req_if import sbmq_pkg::*;;
	logic                     valid;
	logic                     ready;
	op_t                      operation;
	logic [QID_W-1:0]         queue_id;
	logic signed [DATA_W-1:0] value;

	modport source (output valid, operation, queue_id, value, input ready);
	modport sink   (input valid, operation, queue_id, value, output ready);
endinterface

interface sbmq_rsp_if import sbmq_pkg::*;;
	logic                     valid;
	logic                     ready;
	status_t                  status;
	logic signed [DATA_W-1:0] data_out;

	modport source (output valid, status, data_out, input ready);
	modport sink   (input valid, status, data_out, output ready);
endinterface

`default_nettype wire

@@ rtl/shared_buffer_multi_queue.sv @@
// A request waits in the execute stage, then its result is registered.
// No new request is taken until the previous one has executed; the link
// and data stores are read in the accept cycle and written in the execute
// cycle. A waiting result does not block the next request from being taken.
// Reset: all queues empty, free list at slot 0, fill count 0. No clearing
// pass; slots at or above the fill count read their link as the next slot.
`timescale 1ns / 1ps
`default_nettype none

module shared_buffer_multi_queue import sbmq_pkg::*; #(
	parameter int SLOTS  = 64,
	parameter int QUEUES = 4
) (
	input  wire logic clk,
	input  wire logic arst_n,
	sbmq_req_if.sink  req,
	sbmq_rsp_if.source rsp
);

	localparam int AW = $clog2(SLOTS);
	localparam int PW = $clog2(SLOTS + 1);
	localparam int QW = (QUEUES > 1) ? $clog2(QUEUES) : 1;
	localparam logic [PW-1:0] NIL = PW'(SLOTS);

	// pointer state
	logic [PW-1:0] head_q [QUEUES];
	logic [PW-1:0] tail_q [QUEUES];
	logic [PW-1:0] free_head_q;
	logic [PW-1:0] fill_q;

	// execute stage
	logic                     valid_s1;
	op_t                      op_s1;
	logic [QW-1:0]            qi_s1;
	logic                     qok_s1;
	logic signed [DATA_W-1:0] value_s1;

	// result register
	logic                     rsp_valid_q;
	status_t                  status_q;
	logic signed [DATA_W-1:0] data_out_q;

	logic                req_fire;
	logic [QW-1:0]       qi_in;
	logic                qok_in;
	logic [PW-1:0]       rd_ptr;
	logic [PW-1:0]       link_rd;
	logic [DATA_W-1:0]   data_rd;

	logic                exec;
	logic [PW-1:0]       head_x;
	logic [PW-1:0]       tail_x;
	logic                enq_ok;
	logic                deq_ok;
	logic [PW-1:0]       free_link;
	logic [PW-1:0]       deq_next;
	logic                link_we;
	logic [PW-1:0]       link_wa;

	assign req.ready = !valid_s1;
	assign req_fire  = req.valid && req.ready;

	assign qi_in  = QW'(req.queue_id);
	assign qok_in = int'(req.queue_id) < QUEUES;

	// both stores are read at the pointer the operation will consume
	always_comb begin
		if (req.operation == OP_DEQ) begin
			rd_ptr = qok_in ? head_q[qi_in] : NIL;
		end else begin
			rd_ptr = free_head_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_fire) begin
			valid_s1 <= 1'b1;
		end else if (exec) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			op_s1    <= req.operation;
			qi_s1    <= qi_in;
			qok_s1   <= qok_in;
			value_s1 <= req.value;
		end
	end

	assign exec = valid_s1 && (!rsp_valid_q || rsp.ready);

	always_comb begin
		head_x = qok_s1 ? head_q[qi_s1] : NIL;
		tail_x = qok_s1 ? tail_q[qi_s1] : NIL;
		enq_ok = (op_s1 == OP_ENQ) && qok_s1 && (free_head_q != NIL);
		deq_ok = (op_s1 == OP_DEQ) && (head_x != NIL);
		// never-allocated slots chain to the next slot; the last one to null
		free_link = (free_head_q >= fill_q) ? free_head_q + PW'(1) : link_rd;
		// the tail's link is never written, so a single-entry queue ends here
		deq_next  = (head_x == tail_x) ? NIL : link_rd;
		// append links the old tail to the new slot; a dequeue pushes its slot
		// onto the free list. Either way the written value is the free head.
		link_we = exec && ((enq_ok && (head_x != NIL)) || deq_ok);
		link_wa = (op_s1 == OP_ENQ) ? tail_x : head_x;
	end

	sbmq_store #(
		.DEPTH (SLOTS),
		.WIDTH (PW)
	) u_link (
		.clk     (clk),
		.wr_en   (link_we),
		.wr_addr (link_wa[AW-1:0]),
		.wr_data (free_head_q),
		.rd_en   (req_fire),
		.rd_addr (rd_ptr[AW-1:0]),
		.rd_data (link_rd)
	);

	sbmq_store #(
		.DEPTH (SLOTS),
		.WIDTH (DATA_W)
	) u_data (
		.clk     (clk),
		.wr_en   (exec && enq_ok),
		.wr_addr (free_head_q[AW-1:0]),
		.wr_data (value_s1),
		.rd_en   (req_fire),
		.rd_addr (rd_ptr[AW-1:0]),
		.rd_data (data_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < QUEUES; i++) begin
				head_q[i] <= NIL;
				tail_q[i] <= NIL;
			end
			free_head_q <= '0;
			fill_q      <= '0;
		end else if (exec) begin
			if (enq_ok) begin
				free_head_q   <= free_link;
				tail_q[qi_s1] <= free_head_q;
				if (head_x == NIL) begin
					head_q[qi_s1] <= free_head_q;
				end
				if (free_head_q == fill_q) begin
					fill_q <= fill_q + PW'(1);
				end
			end else if (deq_ok) begin
				head_q[qi_s1] <= deq_next;
				free_head_q   <= head_x;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (exec) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			if (enq_ok || deq_ok) begin
				status_q <= ST_DONE;
			end else if (op_s1 == OP_ENQ) begin
				status_q <= ST_FULL;
			end else begin
				status_q <= ST_EMPTY;
			end
			data_out_q <= deq_ok ? data_rd : '0;
		end
	end

	assign rsp.valid    = rsp_valid_q;
	assign rsp.status   = status_q;
	assign rsp.data_out = data_out_q;

endmodule

`default_nettype wire

@@ rtl/sbmq_store.sv @@
// Single-port-write, single-port-read store with registered read data.
// Used for the link store and the data store. No package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module sbmq_store #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

@@ rtl/sbmq_checker.sv @@
// Port-level checks for shared_buffer_multi_queue, attached by bind.
// Depends on sbmq_pkg and the top level's channel interfaces.
`timescale 1ns / 1ps
`default_nettype none

module sbmq_checker import sbmq_pkg::*; (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              req_valid,
	input wire logic              req_ready,
	input wire logic              rsp_valid,
	input wire logic              rsp_ready,
	input wire logic [1:0]        rsp_status,
	input wire logic [DATA_W-1:0] rsp_data_out
);

	// a stalled result transaction keeps its contents
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=>
			rsp_valid && $stable(rsp_status) && $stable(rsp_data_out))
		else $error("result changed while stalled");

	// one request in flight: no request taken in the cycle after another
	a_req_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted on consecutive cycles");

	// full and empty results carry zero data
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status != ST_DONE) |-> rsp_data_out == '0)
		else $error("nonzero data on a failed operation");

	// an idle output only turns valid after a request has passed the execute stage
	a_rsp_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
		else $error("result appeared without a matching request");

endmodule

bind shared_buffer_multi_queue sbmq_checker u_sbmq_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.rsp_status   (rsp.status),
	.rsp_data_out (rsp.data_out)
);

`default_nettype wire

@@ dv/tb_shared_buffer_multi_queue.sv @@
// Testbench for shared_buffer_multi_queue: a linked-slot queue predictor checks every
// response. Depends on sbmq_pkg and the sbmq_req_if / sbmq_rsp_if interfaces.
`timescale 1ns / 1ps

module tb_shared_buffer_multi_queue;
	import sbmq_pkg::*;

	localparam int SLOTS       = 64;
	localparam int QUEUES      = 4;
	localparam int PTR_W       = 7;
	localparam int SLOT_W      = $clog2(SLOTS);
	localparam logic [PTR_W-1:0] NIL = PTR_W'(SLOTS);
	localparam int SEG_LEN     = 96;
	localparam int SEGS_PER_PH = 3;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		op_t                      operation;
		logic [QID_W-1:0]         queue_id;
		logic signed [DATA_W-1:0] value;
	} queue_req_t;

	typedef struct packed {
		status_t                  status;
		logic signed [DATA_W-1:0] data_out;
	} queue_rsp_t;

	logic clk = 1'b0;
	logic arst_n;

	sbmq_req_if req_ch ();
	sbmq_rsp_if rsp_ch ();

	shared_buffer_multi_queue #(
		.SLOTS  (SLOTS),
		.QUEUES (QUEUES)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always #2 clk = ~clk;

	queue_req_t pend_reqs[$];
	queue_rsp_t exp_rsps[$];
	int         send_idle_pct  = 0;
	int         recv_stall_pct = 0;
	int         err_count      = 0;
	int         cycle_count    = 0;

	// predictor state: data and link per slot, head/tail per queue, free list head
	logic signed [DATA_W-1:0] slot_data [SLOTS];
	logic [PTR_W-1:0]         slot_link [SLOTS];
	logic [PTR_W-1:0]         q_head    [QUEUES];
	logic [PTR_W-1:0]         q_tail    [QUEUES];
	logic [PTR_W-1:0]         free_slot;

	function automatic void clear_queue_model();
		for (int i = 0; i < SLOTS; i++) begin
			slot_link[i] = PTR_W'(i + 1);
			slot_data[i] = '0;
		end
		for (int i = 0; i < QUEUES; i++) begin
			q_head[i] = NIL;
			q_tail[i] = NIL;
		end
		free_slot = '0;
	endfunction

	function automatic void apply_queue_op(queue_req_t r);
		queue_rsp_t       res;
		logic [PTR_W-1:0] slot;
		res.status   = ST_DONE;
		res.data_out = '0;
		if (r.operation == OP_ENQ) begin
			if (free_slot == NIL || int'(r.queue_id) >= QUEUES) begin
				res.status = ST_FULL;
			end else begin
				slot      = free_slot;
				free_slot = slot_link[slot[SLOT_W-1:0]];
				// head is tested, not tail: a drained queue keeps a stale tail
				if (q_head[r.queue_id] == NIL)
					q_head[r.queue_id] = slot;
				else
					slot_link[q_tail[r.queue_id][SLOT_W-1:0]] = slot;
				slot_link[slot[SLOT_W-1:0]] = NIL;
				q_tail[r.queue_id]          = slot;
				slot_data[slot[SLOT_W-1:0]] = r.value;
			end
		end else begin
			if (int'(r.queue_id) >= QUEUES || q_head[r.queue_id] == NIL) begin
				res.status = ST_EMPTY;
			end else begin
				slot                        = q_head[r.queue_id];
				q_head[r.queue_id]          = slot_link[slot[SLOT_W-1:0]];
				slot_link[slot[SLOT_W-1:0]] = free_slot;
				free_slot                   = slot;
				res.data_out                = slot_data[slot[SLOT_W-1:0]];
			end
		end
		exp_rsps.push_back(res);
	endfunction

	task automatic queue_request(op_t op, int qid, logic [DATA_W-1:0] val);
		queue_req_t r;
		r.operation = op;
		r.queue_id  = QID_W'(qid);
		r.value     = val;
		pend_reqs.push_back(r);
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		queue_req_t r;
		if (!arst_n) begin
			req_ch.valid     <= 1'b0;
			req_ch.operation <= OP_ENQ;
			req_ch.queue_id  <= '0;
			req_ch.value     <= '0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				r.operation = req_ch.operation;
				r.queue_id  = req_ch.queue_id;
				r.value     = req_ch.value;
				apply_queue_op(r);
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (pend_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					r = pend_reqs.pop_front();
					req_ch.valid     <= 1'b1;
					req_ch.operation <= r.operation;
					req_ch.queue_id  <= r.queue_id;
					req_ch.value     <= r.value;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// response monitor and checker
	always @(posedge clk or negedge arst_n) begin
		queue_rsp_t want;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (exp_rsps.size() == 0) begin
					$display("%0t: unexpected response status=%0d data_out=%h", $time,
						rsp_ch.status, rsp_ch.data_out);
					err_count++;
				end else begin
					want = exp_rsps.pop_front();
					if (rsp_ch.status !== want.status) begin
						$display("%0t: status mismatch expected=%0d actual=%0d", $time,
							want.status, rsp_ch.status);
						err_count++;
					end
					if (rsp_ch.data_out !== want.data_out) begin
						$display("%0t: data_out mismatch expected=%h actual=%h", $time,
							want.data_out, rsp_ch.data_out);
						err_count++;
					end
				end
			end
			rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		int seg;
		int enq_pct;
		req_ch.valid     = 1'b0;
		req_ch.operation = OP_ENQ;
		req_ch.queue_id  = '0;
		req_ch.value     = '0;
		rsp_ch.ready     = 1'b0;
		arst_n           = 1'b0;
		clear_queue_model();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty dequeues, value extremes, FIFO order, reuse after drain
		for (int q = 0; q < QUEUES; q++)
			queue_request(OP_DEQ, q, 32'hdead_beef);
		queue_request(OP_ENQ, 0, 32'h8000_0000);
		queue_request(OP_ENQ, 1, 32'h7fff_ffff);
		queue_request(OP_ENQ, 2, 32'h0000_0000);
		queue_request(OP_ENQ, 3, 32'hffff_ffff);
		queue_request(OP_ENQ, 0, 32'h5555_5555);
		queue_request(OP_ENQ, 0, 32'haaaa_aaaa);
		for (int i = 0; i < 4; i++)
			queue_request(OP_DEQ, 0, '0);
		for (int q = 1; q < QUEUES; q++)
			queue_request(OP_DEQ, q, '0);
		queue_request(OP_DEQ, 3, '0);
		// q0 now drained with a stale tail
		queue_request(OP_ENQ, 0, 32'h1234_5678);
		queue_request(OP_DEQ, 0, '0);

		// random: enqueue-heavy segments reach full, dequeue-heavy ones reach empty
		seg = 0;
		for (int ph = 0; ph < 4; ph++) begin
			for (int s = 0; s < SEGS_PER_PH; s++) begin
				case (seg % 3)
					0: begin
						enq_pct = 90;
					end
					1: begin
						enq_pct = 10;
					end
					default: begin
						enq_pct = 50;
					end
				endcase
				for (int i = 0; i < SEG_LEN; i++)
					queue_request(($urandom_range(0, 99) < enq_pct) ? OP_ENQ : OP_DEQ,
						$urandom_range(0, QUEUES - 1), $urandom());
				seg++;
			end
			// sender holds off until every response of the phase is back
			while (pend_reqs.size() != 0 || req_ch.valid || exp_rsps.size() != 0)
				@(negedge clk);
			case (ph)
				0: begin
					send_idle_pct  = 82;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct  = 0;
					recv_stall_pct = 82;
				end
				2: begin
					send_idle_pct  = 26;
					recv_stall_pct = 26;
				end
				default: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
			endcase
		end

		while (exp_rsps.size() != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
		if (err_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/sbmq_pkg.sv
rtl/sbmq_if.sv
rtl/sbmq_store.sv
rtl/shared_buffer_multi_queue.sv
rtl/sbmq_checker.sv
dv/tb_shared_buffer_multi_queue.sv
